// ===== design/plti_pkg.sv =====
// ============================================================================
// plti_pkg: shared types and constants of the piecewise linear interpolator
// Word formats of the request and result channels, load and evaluate codes,
// configuration register indexes and the fixed arithmetic widths.
// ============================================================================
package plti_pkg;

    // Width of a table value, a breakpoint and a query (signed Q16.16).
    localparam int VALUE_WIDTH = 32;
    // Width of a query after the periodic wrap; two guard bits hold the
    // intermediate values of the wrap without overflow.
    localparam int QUERY_WIDTH = VALUE_WIDTH + 2;
    // Shared divider: a full product over one value-wide divisor.
    localparam int DIVIDEND_WIDTH = 2 * VALUE_WIDTH;
    localparam int DIVISOR_WIDTH  = VALUE_WIDTH;
    // The quotient of the interpolation is limited to two to the power of this bit.
    localparam int QUOT_LIMIT_BIT = 40;

    // Request modes.
    localparam logic [1:0] MODE_LOAD_POINT = 2'd0;
    localparam logic [1:0] MODE_LOAD_VALUE = 2'd1;
    localparam logic [1:0] MODE_EVALUATE   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POINT_COUNT   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COLUMN_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PERIODIC_MODE = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_LOW     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_HIGH    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PERIOD_LENGTH = 3'd5;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [5:0]                    point_index;
        logic [2:0]                    column_index;
        logic signed [VALUE_WIDTH-1:0] data_value;
    } req_word_t;

    typedef struct packed {
        logic [2:0]                    out_column;
        logic signed [VALUE_WIDTH-1:0] out_value;
        logic                          last_column;
    } rsp_word_t;

endpackage

// ===== design/plti_ram.sv =====
// ============================================================================
// plti_ram: generic synchronous RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module plti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/plti_div.sv =====
// ============================================================================
// plti_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, shared by the periodic
// wrap (remainder) and the interpolation (quotient).
// ============================================================================
module plti_div
    import plti_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic                      busy,
    output logic                      done,
    output logic [DIVIDEND_WIDTH-1:0] quotient,
    output logic [DIVISOR_WIDTH-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_WIDTH);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [DIVIDEND_WIDTH-1:0] quo_reg;
    logic [DIVIDEND_WIDTH-1:0] quo_next;
    logic [DIVISOR_WIDTH-1:0]  rem_reg;
    logic [DIVISOR_WIDTH-1:0]  rem_next;
    logic [DIVISOR_WIDTH-1:0]  dvs_reg;
    logic [DIVISOR_WIDTH:0]    trial;
    logic [DIVISOR_WIDTH:0]    diff;

    // The shifted partial remainder is tried against the divisor.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[DIVISOR_WIDTH-1:0];
            quo_next = {quo_reg[DIVIDEND_WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DIVISOR_WIDTH-1:0];
            quo_next = {quo_reg[DIVIDEND_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CNT_W'(DIVIDEND_WIDTH - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("divider reports done while still busy");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !$past(done))
        else $error("divider done is not a single pulse");

endmodule

// ===== design/piecewise_linear_table_interp.sv =====
// ============================================================================
// piecewise_linear_table_interp: piecewise linear table lookup
// Breakpoint and value tables in RAM, segment search from a cached index,
// one Q16.16 value per column, clamped or interpolated through a shared divider.
// ============================================================================
// A load word (point or value) is written into its table in the cycle it is
// accepted, so loads stream at one word per cycle while no evaluate word is
// in progress. An evaluate word occupies the block until its last column has
// been handed to the result register: the periodic wrap checks the low and
// then the high bound, and every bound that the query crosses starts a
// remainder division; the end-row check reads the first and last breakpoint,
// the segment walk steps one breakpoint at a time from the cached segment
// and then fetches the segment ends. A column clamped to an end row reads
// its value from the table; an interpolated one goes through the multiply
// and the bit-serial 64-step divider. The result register lets the next
// word be accepted while the last result still waits on stall.
module piecewise_linear_table_interp
    import plti_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_COLUMNS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  req_word_t                  req_word,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output rsp_word_t                  rsp_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]     cfg_data
);

    localparam int RW  = $clog2(TABLE_DEPTH);
    localparam int IW  = RW + 1;
    localparam int VA  = $clog2(TABLE_DEPTH * MAX_COLUMNS);
    localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SW  = VALUE_WIDTH + 11;

    localparam logic signed [SW-1:0] SUM_MAX = (SW'(1) <<< (VALUE_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SUM_MIN = -(SW'(1) <<< (VALUE_WIDTH - 1));
    localparam logic [DIVIDEND_WIDTH-1:0] QUOT_LIMIT = DIVIDEND_WIDTH'(1) << QUOT_LIMIT_BIT;

    typedef enum logic [20:0] {
        S_IDLE       = 21'b1 << 0,
        S_WRAP_LO    = 21'b1 << 1,
        S_WAIT_LO    = 21'b1 << 2,
        S_WRAP_HI    = 21'b1 << 3,
        S_WAIT_HI    = 21'b1 << 4,
        S_END_A      = 21'b1 << 5,
        S_END_B      = 21'b1 << 6,
        S_END_C      = 21'b1 << 7,
        S_WALK_FIRST = 21'b1 << 8,
        S_WALK_DOWN  = 21'b1 << 9,
        S_WALK_UP    = 21'b1 << 10,
        S_SEG_A      = 21'b1 << 11,
        S_SEG_B      = 21'b1 << 12,
        S_SEG_C      = 21'b1 << 13,
        S_COL_A      = 21'b1 << 14,
        S_COL_B      = 21'b1 << 15,
        S_COL_C      = 21'b1 << 16,
        S_MUL        = 21'b1 << 17,
        S_DIV_START  = 21'b1 << 18,
        S_DIV        = 21'b1 << 19,
        S_OUT        = 21'b1 << 20
    } state_t;

    // Configuration registers.
    logic [6:0]                    point_count_reg;
    logic [3:0]                    column_count_reg;
    logic                          periodic_reg;
    logic signed [VALUE_WIDTH-1:0] range_low_reg;
    logic signed [VALUE_WIDTH-1:0] range_high_reg;
    logic [VALUE_WIDTH-2:0]        period_reg;

    // Control state.
    state_t          state_reg;
    state_t          state_next;
    logic [RW-1:0]   cached_reg;
    logic [RW-1:0]   cached_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;

    // Working payload.
    logic signed [QUERY_WIDTH-1:0] q_reg;
    logic signed [QUERY_WIDTH-1:0] q_next;
    logic [IW-1:0]                 idx_reg;
    logic [IW-1:0]                 idx_next;
    logic [RW-1:0]                 src_reg;
    logic [RW-1:0]                 src_next;
    logic                          interp_reg;
    logic                          interp_next;
    logic [CIW-1:0]                col_reg;
    logic [CIW-1:0]                col_next;
    logic signed [VALUE_WIDTH-1:0] x0_reg;
    logic signed [VALUE_WIDTH-1:0] x0_next;
    logic signed [VALUE_WIDTH-1:0] x1_reg;
    logic signed [VALUE_WIDTH-1:0] x1_next;
    logic signed [VALUE_WIDTH-1:0] y0_reg;
    logic signed [VALUE_WIDTH-1:0] y0_next;
    logic [VALUE_WIDTH-1:0]        mag_a_reg;
    logic [VALUE_WIDTH-1:0]        mag_a_next;
    logic [VALUE_WIDTH-1:0]        mag_b_reg;
    logic [VALUE_WIDTH-1:0]        mag_b_next;
    logic [VALUE_WIDTH-1:0]        mag_d_reg;
    logic [VALUE_WIDTH-1:0]        mag_d_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic                          dzero_reg;
    logic                          dzero_next;
    logic [DIVIDEND_WIDTH-1:0]     prod_reg;
    logic [DIVIDEND_WIDTH-1:0]     prod_next;
    logic signed [VALUE_WIDTH-1:0] result_reg;
    logic signed [VALUE_WIDTH-1:0] result_next;
    rsp_word_t                     rsp_word_reg;
    rsp_word_t                     rsp_word_next;

    // Table memories.
    logic                   bp_we;
    logic [RW-1:0]          bp_waddr;
    logic [RW-1:0]          bp_raddr;
    logic [VALUE_WIDTH-1:0] bp_rdata;
    logic                   val_we;
    logic [VA-1:0]          val_waddr;
    logic [VA-1:0]          val_raddr;
    logic [VALUE_WIDTH-1:0] val_rdata;

    // Divider.
    logic                      div_start;
    logic [DIVIDEND_WIDTH-1:0] div_dividend;
    logic [DIVISOR_WIDTH-1:0]  div_divisor;
    logic                      div_busy;
    logic                      div_done;
    logic [DIVIDEND_WIDTH-1:0] div_quotient;
    logic [DIVISOR_WIDTH-1:0]  div_remainder;

    // Derived values.
    logic [RW-1:0]                 n_m1;
    logic [RW-1:0]                 n_m2;
    logic [CIW-1:0]                cols_m1;
    logic                          req_take;
    logic                          wrap_on;
    logic signed [QUERY_WIDTH-1:0] low_ext;
    logic signed [QUERY_WIDTH-1:0] high_ext;
    logic signed [QUERY_WIDTH-1:0] low_diff;
    logic signed [QUERY_WIDTH-1:0] high_diff;
    logic [VALUE_WIDTH-2:0]        wrap_adj;
    logic signed [QUERY_WIDTH-1:0] bp_ext;
    logic [RW-1:0]                 start_idx;
    logic [IW-1:0]                 idx_inc;
    logic [IW-1:0]                 idx_dec;
    logic                          fin_en;
    logic [IW-1:0]                 fin_idx;
    logic [RW-1:0]                 seg_idx;
    logic signed [QUERY_WIDTH-1:0] a_diff;
    logic signed [VALUE_WIDTH:0]   b_diff;
    logic signed [VALUE_WIDTH:0]   d_diff;
    logic [QUERY_WIDTH-1:0]        a_mag;
    logic [VALUE_WIDTH:0]          b_mag;
    logic [VALUE_WIDTH:0]          d_mag;
    logic [QUOT_LIMIT_BIT:0]       quot_sat;
    logic signed [SW-1:0]          sum;
    logic signed [VALUE_WIDTH-1:0] sum_sat;
    logic                          out_load;

    // Out-of-range register settings are pulled into the usable range.
    always_comb
    begin
        if (point_count_reg < 7'd2)
        begin
            n_m1 = RW'(1);
        end
        else if (32'(point_count_reg) > TABLE_DEPTH)
        begin
            n_m1 = RW'(TABLE_DEPTH - 1);
        end
        else
        begin
            n_m1 = RW'(32'(point_count_reg) - 1);
        end

        if (column_count_reg == 4'd0)
        begin
            cols_m1 = '0;
        end
        else if (32'(column_count_reg) > MAX_COLUMNS)
        begin
            cols_m1 = CIW'(MAX_COLUMNS - 1);
        end
        else
        begin
            cols_m1 = CIW'(32'(column_count_reg) - 1);
        end
    end

    assign n_m2      = n_m1 - 1'b1;
    assign req_take  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Periodic wrap: the query moves into range by whole periods. The
    // distance to the bound modulo the period gives the final offset, so
    // only the remainder of one division is needed per bound.
    assign wrap_on   = periodic_reg && (period_reg != '0);
    assign low_ext   = QUERY_WIDTH'(range_low_reg);
    assign high_ext  = QUERY_WIDTH'(range_high_reg);
    assign low_diff  = low_ext - q_reg;
    assign high_diff = q_reg - high_ext;
    assign wrap_adj  = (div_remainder[VALUE_WIDTH-2:0] == '0) ? '0
                     : period_reg - div_remainder[VALUE_WIDTH-2:0];

    assign bp_ext    = QUERY_WIDTH'($signed(bp_rdata));
    assign start_idx = (cached_reg > n_m1) ? n_m1 : cached_reg;
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign seg_idx   = (fin_idx > {1'b0, n_m2}) ? n_m2 : fin_idx[RW-1:0];

    // Interpolation operands: sign and magnitude of each difference.
    assign a_diff = q_reg - QUERY_WIDTH'(x0_reg);
    assign b_diff = (VALUE_WIDTH + 1)'($signed(val_rdata)) - (VALUE_WIDTH + 1)'(y0_reg);
    assign d_diff = (VALUE_WIDTH + 1)'(x1_reg) - (VALUE_WIDTH + 1)'(x0_reg);
    assign a_mag  = a_diff[QUERY_WIDTH-1] ? QUERY_WIDTH'(-a_diff) : QUERY_WIDTH'(a_diff);
    assign b_mag  = b_diff[VALUE_WIDTH] ? (VALUE_WIDTH + 1)'(-b_diff)
                  : (VALUE_WIDTH + 1)'(b_diff);
    assign d_mag  = d_diff[VALUE_WIDTH] ? (VALUE_WIDTH + 1)'(-d_diff)
                  : (VALUE_WIDTH + 1)'(d_diff);

    // Final step: limited quotient added to or taken from the left value,
    // then saturated to the value width.
    always_comb
    begin
        if (div_quotient > QUOT_LIMIT)
        begin
            quot_sat = QUOT_LIMIT[QUOT_LIMIT_BIT:0];
        end
        else
        begin
            quot_sat = div_quotient[QUOT_LIMIT_BIT:0];
        end
        if (neg_reg)
        begin
            sum = SW'(y0_reg) - $signed(SW'(quot_sat));
        end
        else
        begin
            sum = SW'(y0_reg) + $signed(SW'(quot_sat));
        end
        if (sum > SUM_MAX)
        begin
            sum_sat = SUM_MAX[VALUE_WIDTH-1:0];
        end
        else if (sum < SUM_MIN)
        begin
            sum_sat = SUM_MIN[VALUE_WIDTH-1:0];
        end
        else
        begin
            sum_sat = sum[VALUE_WIDTH-1:0];
        end
    end

    // Load words go straight into the tables; addresses outside the table
    // are dropped.
    always_comb
    begin
        bp_we     = req_take && (req_word.mode == MODE_LOAD_POINT)
                 && (32'(req_word.point_index) < TABLE_DEPTH);
        val_we    = req_take && (req_word.mode == MODE_LOAD_VALUE)
                 && (32'(req_word.point_index) < TABLE_DEPTH)
                 && (32'(req_word.column_index) < MAX_COLUMNS);
        bp_waddr  = RW'(req_word.point_index);
        val_waddr = VA'(32'(req_word.point_index) * MAX_COLUMNS
                        + 32'(req_word.column_index));
    end

    assign out_load = (state_reg == S_OUT) && (!rsp_valid_reg || !rsp_stall);

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cached_next    = cached_reg;
        q_next         = q_reg;
        idx_next       = idx_reg;
        src_next       = src_reg;
        interp_next    = interp_reg;
        col_next       = col_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y0_next        = y0_reg;
        mag_a_next     = mag_a_reg;
        mag_b_next     = mag_b_reg;
        mag_d_next     = mag_d_reg;
        neg_next       = neg_reg;
        dzero_next     = dzero_reg;
        prod_next      = prod_reg;
        result_next    = result_reg;
        rsp_word_next  = rsp_word_reg;
        bp_raddr       = src_reg;
        val_raddr      = VA'(32'(src_reg) * MAX_COLUMNS + 32'(col_reg));
        div_start      = 1'b0;
        div_dividend   = prod_reg;
        div_divisor    = mag_d_reg;
        fin_en         = 1'b0;
        fin_idx        = idx_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take && (req_word.mode == MODE_EVALUATE))
                begin
                    q_next     = QUERY_WIDTH'(req_word.data_value);
                    state_next = S_WRAP_LO;
                end
            end
            S_WRAP_LO:
            begin
                div_dividend = DIVIDEND_WIDTH'($unsigned(low_diff));
                div_divisor  = DIVISOR_WIDTH'(period_reg);
                if (wrap_on && (q_reg < low_ext))
                begin
                    div_start  = 1'b1;
                    state_next = S_WAIT_LO;
                end
                else
                begin
                    state_next = S_WRAP_HI;
                end
            end
            S_WAIT_LO:
            begin
                if (div_done)
                begin
                    q_next     = low_ext + $signed(QUERY_WIDTH'(wrap_adj));
                    state_next = S_WRAP_HI;
                end
            end
            S_WRAP_HI:
            begin
                div_dividend = DIVIDEND_WIDTH'($unsigned(high_diff));
                div_divisor  = DIVISOR_WIDTH'(period_reg);
                if (wrap_on && (q_reg > high_ext))
                begin
                    div_start  = 1'b1;
                    state_next = S_WAIT_HI;
                end
                else
                begin
                    state_next = S_END_A;
                end
            end
            S_WAIT_HI:
            begin
                if (div_done)
                begin
                    q_next     = high_ext - $signed(QUERY_WIDTH'(wrap_adj));
                    state_next = S_END_A;
                end
            end
            S_END_A:
            begin
                bp_raddr   = '0;
                state_next = S_END_B;
            end
            S_END_B:
            begin
                x0_next    = $signed(bp_rdata);
                bp_raddr   = n_m1;
                state_next = S_END_C;
            end
            S_END_C:
            begin
                col_next = '0;
                bp_raddr = start_idx;
                if (q_reg <= QUERY_WIDTH'(x0_reg))
                begin
                    src_next    = '0;
                    cached_next = '0;
                    interp_next = 1'b0;
                    state_next  = S_COL_A;
                end
                else if (q_reg >= bp_ext)
                begin
                    src_next    = n_m1;
                    cached_next = n_m1;
                    interp_next = 1'b0;
                    state_next  = S_COL_A;
                end
                else
                begin
                    idx_next   = {1'b0, start_idx};
                    state_next = S_WALK_FIRST;
                end
            end
            S_WALK_FIRST:
            begin
                if (q_reg <= bp_ext)
                begin
                    if ((idx_reg != '0) && (q_reg < bp_ext))
                    begin
                        idx_next   = idx_dec;
                        bp_raddr   = idx_dec[RW-1:0];
                        state_next = S_WALK_DOWN;
                    end
                    else
                    begin
                        fin_en  = 1'b1;
                        fin_idx = idx_reg;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    bp_raddr   = idx_inc[RW-1:0];
                    state_next = S_WALK_UP;
                end
            end
            S_WALK_DOWN:
            begin
                if ((idx_reg != '0) && (q_reg < bp_ext))
                begin
                    idx_next = idx_dec;
                    bp_raddr = idx_dec[RW-1:0];
                end
                else
                begin
                    fin_en  = 1'b1;
                    fin_idx = idx_reg;
                end
            end
            S_WALK_UP:
            begin
                if ((idx_reg < {1'b0, n_m1}) && (q_reg > bp_ext))
                begin
                    idx_next = idx_inc;
                    bp_raddr = idx_inc[RW-1:0];
                end
                else
                begin
                    fin_en  = 1'b1;
                    fin_idx = idx_dec;
                end
            end
            S_SEG_A:
            begin
                bp_raddr   = src_reg;
                state_next = S_SEG_B;
            end
            S_SEG_B:
            begin
                x0_next    = $signed(bp_rdata);
                bp_raddr   = src_reg + 1'b1;
                state_next = S_SEG_C;
            end
            S_SEG_C:
            begin
                x1_next    = $signed(bp_rdata);
                state_next = S_COL_A;
            end
            S_COL_A:
            begin
                state_next = S_COL_B;
            end
            S_COL_B:
            begin
                y0_next = $signed(val_rdata);
                if (interp_reg)
                begin
                    val_raddr  = VA'((32'(src_reg) + 1) * MAX_COLUMNS + 32'(col_reg));
                    state_next = S_COL_C;
                end
                else
                begin
                    result_next = $signed(val_rdata);
                    state_next  = S_OUT;
                end
            end
            S_COL_C:
            begin
                mag_a_next = a_mag[VALUE_WIDTH-1:0];
                mag_b_next = b_mag[VALUE_WIDTH-1:0];
                mag_d_next = d_mag[VALUE_WIDTH-1:0];
                neg_next   = a_diff[QUERY_WIDTH-1] ^ b_diff[VALUE_WIDTH] ^ d_diff[VALUE_WIDTH];
                dzero_next = (d_diff == '0);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = DIVIDEND_WIDTH'(mag_a_reg) * DIVIDEND_WIDTH'(mag_b_reg);
                if (dzero_reg)
                begin
                    result_next = y0_reg;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    result_next = sum_sat;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_word_next.out_column  = 3'(col_reg);
                    rsp_word_next.out_value   = result_reg;
                    rsp_word_next.last_column = (col_reg == cols_m1);
                    if (col_reg == cols_m1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = S_COL_A;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The walk has settled: the segment start is held inside the table
        // and becomes the cached start for the next query.
        if (fin_en)
        begin
            src_next    = seg_idx;
            cached_next = seg_idx;
            interp_next = 1'b1;
            state_next  = S_SEG_A;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cached_reg       <= '0;
            rsp_valid_reg    <= 1'b0;
            point_count_reg  <= 7'd2;
            column_count_reg <= 4'd1;
            periodic_reg     <= 1'b0;
            range_low_reg    <= '0;
            range_high_reg   <= 32'sd65536;
            period_reg       <= 31'd65536;
        end
        else
        begin
            state_reg     <= state_next;
            cached_reg    <= cached_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                priority case (cfg_index)
                    CFG_POINT_COUNT:   point_count_reg  <= cfg_data[6:0];
                    CFG_COLUMN_COUNT:  column_count_reg <= cfg_data[3:0];
                    CFG_PERIODIC_MODE: periodic_reg     <= cfg_data[0];
                    CFG_RANGE_LOW:     range_low_reg    <= $signed(cfg_data);
                    CFG_RANGE_HIGH:    range_high_reg   <= $signed(cfg_data);
                    CFG_PERIOD_LENGTH: period_reg       <= cfg_data[VALUE_WIDTH-2:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        idx_reg      <= idx_next;
        src_reg      <= src_next;
        interp_reg   <= interp_next;
        col_reg      <= col_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y0_reg       <= y0_next;
        mag_a_reg    <= mag_a_next;
        mag_b_reg    <= mag_b_next;
        mag_d_reg    <= mag_d_next;
        neg_reg      <= neg_next;
        dzero_reg    <= dzero_next;
        prod_reg     <= prod_next;
        result_reg   <= result_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    plti_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_bp_ram (
        .clk   (clk),
        .we    (bp_we),
        .waddr (bp_waddr),
        .wdata (req_word.data_value),
        .raddr (bp_raddr),
        .rdata (bp_rdata)
    );

    plti_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH * MAX_COLUMNS)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (req_word.data_value),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    plti_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider started while busy");
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider still running while the block is idle");
    assert property (@(posedge clk) disable iff (!rst_n) req_take |-> (state_reg == S_IDLE))
        else $error("word accepted while an evaluation is in progress");
    assert property (@(posedge clk) disable iff (!rst_n) out_load |-> (!rsp_valid || !rsp_stall))
        else $error("result register overwritten before it was taken");

endmodule
